// File: src/wsfb_pkg.sv
// ----------------------------------------------------------------------------
// wsfb_pkg
// shared types, constants and helpers of the masked websocket frame builder
// ----------------------------------------------------------------------------
package wsfb_pkg;

  // length field width of the frame builder, 17..64
  localparam int LENGTH_BITS = 32;
  localparam int LEN_W       = (LENGTH_BITS < 32) ? LENGTH_BITS : 32;
  localparam logic [31:0] LEN_MASK = 32'((64'd1 << LEN_W) - 64'd1);

  // longest run of bytes one request can cause: 1 + 1 + 8 + 4 + 1
  localparam int RUN_MAX   = 15;
  localparam int RUN_IDX_W = $clog2(RUN_MAX);

  // configuration register indexes
  localparam int CFG_ADDR_W = 1;
  localparam logic [CFG_ADDR_W-1:0] CFG_KEY_WORD = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_HDR_BYTE = 1'd1;

  localparam logic [31:0] KEY_WORD_RST = 32'h1234_5678;
  localparam logic [7:0]  HDR_BYTE_RST = 8'h82;

  // second header byte codes
  localparam logic [7:0]  MASK_BIT   = 8'h80;
  localparam logic [7:0]  HDR_LEN16  = 8'hFE;
  localparam logic [7:0]  HDR_LEN64  = 8'hFF;
  localparam logic [31:0] LEN7_MAX   = 32'd125;
  localparam logic [31:0] LEN16_LIM  = 32'd65536;

  // mask key offsets inside a start run
  localparam int OFS_LEN7  = 2;
  localparam int OFS_LEN16 = 4;
  localparam int OFS_LEN64 = 10;

  typedef struct packed {
    logic [31:0] remaining;
    logic [1:0]  phase;
    logic        open;
  } wsfb_state_t;

  typedef struct packed {
    logic [RUN_MAX-1:0][7:0] bytes;
    logic [RUN_IDX_W-1:0]    last_idx;
    logic                    eof;
    logic                    busy;
  } wsfb_run_t;

  // mask byte for a payload position mod 4, most significant byte first
  function automatic logic [7:0] key_byte(logic [31:0] key, logic [1:0] phase);
    logic [7:0] b;
    case (phase)
      2'd0:    b = key[31:24];
      2'd1:    b = key[23:16];
      2'd2:    b = key[15:8];
      default: b = key[7:0];
    endcase
    return b;
  endfunction

endpackage

// File: src/wsfb_compose.sv
// ----------------------------------------------------------------------------
// wsfb_compose
// turns one request and the frame state into its byte run and next state
// ----------------------------------------------------------------------------
module wsfb_compose (
  input  logic [7:0]           data_byte_i,
  input  logic                 frame_start_i,
  input  logic [31:0]          payload_length_i,
  input  logic [31:0]          key_word_i,
  input  logic [7:0]           first_header_byte_i,
  input  wsfb_pkg::wsfb_state_t state_i,
  output wsfb_pkg::wsfb_run_t   run_o,
  output wsfb_pkg::wsfb_state_t state_o
);
  import wsfb_pkg::*;

  logic [31:0] len32;
  logic [63:0] len64;
  logic [31:0] rem_m1;
  logic        len_zero;

  assign len32    = payload_length_i & LEN_MASK;
  assign len64    = 64'(len32);
  assign len_zero = (len32 == 32'd0);
  assign rem_m1   = state_i.remaining - 32'd1;

  always_comb begin
    run_o   = '0;
    state_o = state_i;
    if (frame_start_i) begin
      run_o.busy     = 1'b1;
      run_o.bytes[0] = first_header_byte_i;
      run_o.eof      = len_zero || (len32 == 32'd1);
      if (len32 <= LEN7_MAX) begin
        run_o.bytes[1] = MASK_BIT | {1'b0, len32[6:0]};
        for (int i = 0; i < 4; i++) begin
          run_o.bytes[OFS_LEN7+i] = key_byte(key_word_i, 2'(i));
        end
        run_o.bytes[OFS_LEN7+4] = data_byte_i ^ key_byte(key_word_i, 2'd0);
        run_o.last_idx = len_zero ? RUN_IDX_W'(OFS_LEN7 + 3) : RUN_IDX_W'(OFS_LEN7 + 4);
      end else if (len32 < LEN16_LIM) begin
        run_o.bytes[1] = HDR_LEN16;
        run_o.bytes[2] = len32[15:8];
        run_o.bytes[3] = len32[7:0];
        for (int i = 0; i < 4; i++) begin
          run_o.bytes[OFS_LEN16+i] = key_byte(key_word_i, 2'(i));
        end
        run_o.bytes[OFS_LEN16+4] = data_byte_i ^ key_byte(key_word_i, 2'd0);
        run_o.last_idx = RUN_IDX_W'(OFS_LEN16 + 4);
      end else begin
        run_o.bytes[1] = HDR_LEN64;
        for (int i = 0; i < 8; i++) begin
          run_o.bytes[2+i] = len64[63-8*i -: 8];
        end
        for (int i = 0; i < 4; i++) begin
          run_o.bytes[OFS_LEN64+i] = key_byte(key_word_i, 2'(i));
        end
        run_o.bytes[OFS_LEN64+4] = data_byte_i ^ key_byte(key_word_i, 2'd0);
        run_o.last_idx = RUN_IDX_W'(OFS_LEN64 + 4);
      end
      state_o.remaining = len_zero ? 32'd0 : len32 - 32'd1;
      state_o.phase     = len_zero ? 2'd0 : 2'd1;
      state_o.open      = (len32 > 32'd1);
    end else if (state_i.open) begin
      // payload byte of an open frame
      run_o.busy        = 1'b1;
      run_o.bytes[0]    = data_byte_i ^ key_byte(key_word_i, state_i.phase);
      run_o.last_idx    = '0;
      run_o.eof         = (rem_m1 == 32'd0);
      state_o.remaining = rem_m1;
      state_o.phase     = state_i.phase + 2'd1;
      state_o.open      = (rem_m1 != 32'd0);
    end
  end

endmodule

// File: src/websocket_masked_frame_builder_top.sv
// ----------------------------------------------------------------------------
// websocket_masked_frame_builder_top
// builds masked client websocket frames from a stream of payload bytes
// ----------------------------------------------------------------------------
//  channel   | dir | tdata                                  | tuser        | tlast
//  s_axis    | in  | [7:0] data_byte, [39:8] payload_length | frame_start  | -
//  m_axis    | out | [7:0] out_byte                         | last_of_run  | end_of_frame
//  cfg       | in  | index 0 key word, index 1 first_header_byte, write only
//
//  a payload byte of an open frame gives one output byte; a request that opens a
//  frame gives 6 (empty), 7 (up to 125), 9 (below 65536) or 15 bytes, one
//  output byte per cycle from the run register while m_axis_tready is high
//  an input register and a run register let one request wait while the
//  previous run is still being drained
//  reset clears the frame state and loads the default mask key and header
// ----------------------------------------------------------------------------
module websocket_masked_frame_builder_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // request stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [39:0]                     s_axis_tdata,  // data_byte, payload_length
  input  logic                            s_axis_tuser,  // frame_start
  // byte stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [7:0]                      m_axis_tdata,  // out_byte
  output logic                            m_axis_tuser,  // last_of_run
  output logic                            m_axis_tlast,  // end_of_frame
  // configuration
  input  logic                            cfg_we_i,
  input  logic [wsfb_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [31:0]                     cfg_wdata_i
);
  import wsfb_pkg::*;

  // configuration registers
  logic [31:0] key_word_q;
  logic [7:0]  hdr_byte_q;

  // input register
  logic        in_valid_q;
  logic [7:0]  in_data_q;
  logic        in_start_q;
  logic [31:0] in_len_q;

  // frame state
  wsfb_state_t st_q, st_d;

  // run register and its read pointer
  wsfb_run_t            run_d, run_q;
  logic                 run_valid_q;
  logic [RUN_IDX_W-1:0] idx_q;

  logic at_last, run_done, move, accept;

  wsfb_compose u_compose (
    .data_byte_i        (in_data_q),
    .frame_start_i      (in_start_q),
    .payload_length_i   (in_len_q),
    .key_word_i         (key_word_q),
    .first_header_byte_i(hdr_byte_q),
    .state_i            (st_q),
    .run_o              (run_d),
    .state_o            (st_d)
  );

  assign at_last  = (idx_q == run_q.last_idx);
  assign run_done = run_valid_q && m_axis_tready && at_last;
  // a dropped byte leaves at once, otherwise wait for the run register
  assign move     = in_valid_q && (!run_d.busy || !run_valid_q || run_done);
  assign accept   = s_axis_tvalid && s_axis_tready;

  assign s_axis_tready = !in_valid_q || move;

  assign m_axis_tvalid = run_valid_q;
  assign m_axis_tdata  = run_q.bytes[idx_q];
  assign m_axis_tuser  = at_last;
  assign m_axis_tlast  = at_last && run_q.eof;

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_word_q <= KEY_WORD_RST;
      hdr_byte_q <= HDR_BYTE_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_KEY_WORD: key_word_q <= cfg_wdata_i;
        CFG_HDR_BYTE: hdr_byte_q <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (move) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_data_q  <= s_axis_tdata[7:0];
      in_len_q   <= s_axis_tdata[39:8];
      in_start_q <= s_axis_tuser;
    end
  end

  // frame state advances when a request leaves the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (move) begin
      st_q <= st_d;
    end
  end

  // run register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_valid_q <= 1'b0;
      idx_q       <= '0;
    end else if (move && run_d.busy) begin
      run_valid_q <= 1'b1;
      idx_q       <= '0;
    end else if (run_done) begin
      run_valid_q <= 1'b0;
      idx_q       <= '0;
    end else if (run_valid_q && m_axis_tready) begin
      idx_q <= idx_q + RUN_IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (move && run_d.busy) begin
      run_q <= run_d;
    end
  end

endmodule

// File: src/wsfb_checker.sv
// ----------------------------------------------------------------------------
// wsfb_checker
// port level checks of the masked websocket frame builder
// ----------------------------------------------------------------------------
module wsfb_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tuser,
  input logic       m_axis_tlast
);

  // a frame only ends on the last byte of a run
  a_eof_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
    else $error("end of frame inside a run");

  // a taken byte that is not the end of its run is followed by the next one
  a_run_gapless: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tuser |=> m_axis_tvalid)
    else $error("gap inside a byte run");

  // a stalled byte holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
      && $stable(m_axis_tlast))
    else $error("stalled output changed");

endmodule

bind websocket_masked_frame_builder_top wsfb_checker u_wsfb_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser),
  .m_axis_tlast (m_axis_tlast)
);

// File: tb/sv/tb_websocket_masked_frame_builder_top.sv
// ----------------------------------------------------------------------------
// tb_websocket_masked_frame_builder_top
// self-checking bench for the masked websocket frame builder: requests from a
// queue go through a bursty stream driver, a predictor builds the header,
// mask and masked payload bytes each request should produce, and the byte
// stream leaving the block is compared with them in order
// ----------------------------------------------------------------------------
module tb_websocket_masked_frame_builder_top;
  timeunit 1ns;
  timeprecision 1ps;

  import wsfb_pkg::*;

  // one request on the input stream
  typedef struct packed {
    logic [31:0] length;
    logic        start;
    logic [7:0]  data;
  } ws_req_t;

  // one byte expected on the output stream
  typedef struct {
    logic [7:0] value;
    logic       eof;
    logic       last;
  } ws_byte_t;

  // second header byte: mask flag plus a 7-bit length or an escape code
  localparam logic [7:0]  MASK_FLAG    = 8'h80;
  localparam logic [7:0]  LEN_CODE16   = 8'd126;
  localparam logic [7:0]  LEN_CODE64   = 8'd127;
  localparam logic [31:0] KEY_AT_RESET = 32'h1234_5678;
  localparam logic [7:0]  HDR_AT_RESET = 8'h82;

  localparam int DRAIN_CYCLES = 24;   // drain wait, beyond the longest run plus the two register stages
  localparam int LONG_HOLD    = 400;  // receiver hold-off that backs up the block
  localparam int PHASE_ITEMS  = 60;   // byte-producing requests per random phase

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;

  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata  = '0;     // [7:0] data_byte, [39:8] payload_length
  logic        s_axis_tuser  = 1'b0;   // frame_start
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;           // out_byte
  logic        m_axis_tuser;           // last_of_run
  logic        m_axis_tlast;           // end_of_frame
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr_i  = '0;
  logic [31:0]           cfg_wdata_i = '0;

  websocket_masked_frame_builder_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #10 clk_i = ~clk_i;

  // queues: requests waiting for the driver, bytes waiting for the block
  ws_req_t  request_q[$];
  ws_byte_t frame_bytes_q[$];
  ws_byte_t run_q[$];

  // predictor copy of the registers and frame state
  logic [31:0] key_reg       = KEY_AT_RESET;
  logic [7:0]  hdr_reg       = HDR_AT_RESET;
  logic [31:0] pay_left      = '0;
  logic [1:0]  pay_phase     = '0;
  logic        frame_is_open = 1'b0;

  // stimulus bookkeeping: payload still owed by the frame being generated
  logic [31:0] gen_left   = '0;
  int          live_items = 0;

  int err_cnt       = 0;
  int gap_left      = 0;
  int burst_left    = 1;
  int rx_mode       = 0;
  int rx_mode_left  = 0;
  int hold_left     = 0;
  bit long_hold_req = 1'b0;
  bit hold_done     = 1'b0;

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] wanted);
    err_cnt++;
    $display("%0t: mismatch on %s, got %0h, expected %0h", $time, what, got, wanted);
  endtask

  // mask byte for a payload position, key bits 31..24 at position 0
  function automatic logic [7:0] mask_at(input logic [31:0] key, input logic [1:0] pos);
    return 8'(key >> (24 - 8 * int'(pos)));
  endfunction

  function automatic void add_byte(input logic [7:0] value, input logic eof);
    ws_byte_t b;
    b.value = value;
    b.eof   = eof;
    b.last  = 1'b0;
    run_q.push_back(b);
  endfunction

  // bytes one accepted request must produce, in wire order
  function automatic void predict_frame_bytes(input ws_req_t r);
    logic [63:0] len;
    ws_byte_t    b;
    run_q.delete();
    if (r.start) begin
      len = 64'(r.length & LEN_MASK);
      add_byte(hdr_reg, 1'b0);
      if (len <= 64'd125) begin
        add_byte(MASK_FLAG | len[7:0], 1'b0);
      end else if (len < 64'd65536) begin
        add_byte(MASK_FLAG | LEN_CODE16, 1'b0);
        add_byte(len[15:8], 1'b0);
        add_byte(len[7:0], 1'b0);
      end else begin
        add_byte(MASK_FLAG | LEN_CODE64, 1'b0);
        for (int i = 7; i >= 0; i--) add_byte(len[8*i +: 8], 1'b0);
      end
      // empty frame ends on the last mask byte
      for (int i = 0; i < 4; i++) add_byte(mask_at(key_reg, 2'(i)), len == 0 && i == 3);
      if (len == 0) begin
        frame_is_open = 1'b0;
        pay_left      = '0;
        pay_phase     = '0;
      end else begin
        add_byte(r.data ^ mask_at(key_reg, 2'd0), len == 1);
        pay_left      = 32'(len - 64'd1);
        pay_phase     = 2'd1;
        frame_is_open = pay_left != 0;
      end
    end else if (frame_is_open) begin
      pay_left = pay_left - 32'd1;
      add_byte(r.data ^ mask_at(key_reg, pay_phase), pay_left == 0);
      pay_phase = pay_phase + 2'd1;
      if (pay_left == 0) frame_is_open = 1'b0;
    end
    // a byte with no frame open leaves run_q empty
    foreach (run_q[i]) begin
      b      = run_q[i];
      b.last = (i == run_q.size() - 1);
      frame_bytes_q.push_back(b);
    end
  endfunction

  function automatic void push_req(input logic [7:0] data, input logic start,
                                   input logic [31:0] length);
    ws_req_t     r;
    logic [31:0] eff;
    r.data   = data;
    r.start  = start;
    r.length = length;
    request_q.push_back(r);
    // only requests that produce bytes count toward a phase
    if (start) begin
      eff        = length & LEN_MASK;
      gen_left   = (eff == 0) ? 32'd0 : eff - 32'd1;
      live_items++;
    end else if (gen_left != 0) begin
      gen_left = gen_left - 32'd1;
      live_items++;
    end
  endfunction

  // one frame with random content: mostly complete, some cut short by the
  // next start, long lengths only partly sent, now and then stray bytes
  task automatic gen_frame();
    logic [31:0] len;
    int unsigned sel;
    int unsigned body;
    sel = $urandom_range(0, 99);
    if (sel < 60)      len = $urandom_range(0, 12);
    else if (sel < 68) len = $urandom_range(120, 130);
    else if (sel < 78) len = $urandom_range(126, 600);
    else if (sel < 88) len = $urandom_range(65530, 65541);
    else               len = $urandom;
    push_req(8'($urandom), 1'b1, len);
    body = (len == 0) ? 0 : len - 1;
    if (body > 130) body = $urandom_range(0, 6);
    else if ($urandom_range(0, 99) < 12) body = $urandom_range(0, body);
    for (int unsigned i = 0; i < body; i++) push_req(8'($urandom), 1'b0, $urandom);
    if ($urandom_range(0, 99) < 10) begin
      repeat ($urandom_range(1, 3)) push_req(8'($urandom), 1'b0, $urandom);
    end
  endtask

  // wait until every request is taken and every byte is out, then let a
  // dropped byte still inside the block run through
  task automatic wait_drained();
    while (request_q.size() != 0 || frame_bytes_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // register write while idle; the predictor copy follows at once
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= value;
    case (addr)
      CFG_KEY_WORD: key_reg = value;
      CFG_HDR_BYTE: hdr_reg = value[7:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // request driver: bursts of random length separated by random gaps,
  // a gap only ever starts after a handshake so tvalid never drops early
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (gap_left != 0) begin
      s_axis_tvalid <= 1'b0;
      gap_left--;
    end else if (request_q.size() != 0) begin
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= {request_q[0].length, request_q[0].data};
      s_axis_tuser  <= request_q[0].start;
    end else begin
      s_axis_tvalid <= 1'b0;
    end
  end

  // byte receiver: always ready, coin flip or mostly stalled, switching mode
  // at random; one long hold-off on request of the sequence
  always @(negedge clk_i) begin
    if (long_hold_req && !hold_done) begin
      hold_left = LONG_HOLD;
      hold_done = 1'b1;
    end
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      = $urandom_range(0, 2);
        rx_mode_left = $urandom_range(20, 80);
      end
      rx_mode_left--;
      case (rx_mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= 1'($urandom_range(0, 1));
        default: m_axis_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // both handshakes at the rising edge: outputs checked before the request
  // of the same edge adds its bytes, so a fresh byte can never be matched
  always @(posedge clk_i) begin : edge_sample
    ws_byte_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (frame_bytes_q.size() == 0) begin
          report_mismatch("byte with nothing expected", m_axis_tdata, 8'h00);
        end else begin
          want = frame_bytes_q.pop_front();
          if (m_axis_tdata !== want.value) report_mismatch("out_byte", m_axis_tdata, want.value);
          if (m_axis_tlast !== want.eof)
            report_mismatch("end_of_frame", 8'(m_axis_tlast), 8'(want.eof));
          if (m_axis_tuser !== want.last)
            report_mismatch("last_of_run", 8'(m_axis_tuser), 8'(want.last));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predict_frame_bytes(request_q.pop_front());
        burst_left--;
        if (burst_left <= 0) begin
          if ($urandom_range(0, 3) == 0) begin
            gap_left   = 0;
            burst_left = $urandom_range(20, 60);
          end else begin
            gap_left   = $urandom_range(1, 5);
            burst_left = $urandom_range(1, 10);
          end
        end
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part with the reset register values
    push_req(8'h5A, 1'b0, 32'hFFFF_FFFF);   // stray byte, no frame open
    push_req(8'hFF, 1'b1, 32'd0);           // empty frame, data ignored
    push_req(8'hFF, 1'b1, 32'd1);           // single byte frame
    push_req(8'h00, 1'b1, 32'd125);         // longest 7-bit length
    push_req(8'h11, 1'b0, 32'd0);
    push_req(8'h22, 1'b0, 32'd0);
    push_req(8'h33, 1'b1, 32'd126);         // start while open, 16-bit length
    push_req(8'h44, 1'b0, 32'hFFFF_FFFF);
    push_req(8'h55, 1'b1, 32'd65535);       // longest 16-bit length
    push_req(8'h66, 1'b1, 32'd65536);       // shortest 64-bit length
    push_req(8'hAA, 1'b1, 32'hFFFF_FFFF);   // all length bits set
    push_req(8'h01, 1'b0, 32'h0);
    push_req(8'h80, 1'b1, 32'd5);           // mask position wraps around
    push_req(8'h7F, 1'b0, 32'h0);
    push_req(8'hFE, 1'b0, 32'h0);
    push_req(8'hC3, 1'b0, 32'h0);
    push_req(8'h3C, 1'b0, 32'h0);           // closes the frame
    push_req(8'h99, 1'b0, 32'h0);           // dropped after the close
    push_req(8'h12, 1'b1, 32'd3);
    push_req(8'h34, 1'b0, 32'h0);
    wait_drained();
    // new key while a frame is still open
    write_reg(CFG_KEY_WORD, 32'hA5C3_0F96);
    push_req(8'h56, 1'b0, 32'h0);
    wait_drained();

    // random phases, each under its own register setting
    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin
          write_reg(CFG_KEY_WORD, 32'h0000_0000);
          write_reg(CFG_HDR_BYTE, 32'h0000_0000);
        end
        1: begin
          write_reg(CFG_KEY_WORD, 32'hFFFF_FFFF);
          write_reg(CFG_HDR_BYTE, 32'h0000_00FF);
        end
        default: begin
          write_reg(CFG_KEY_WORD, $urandom);
          write_reg(CFG_HDR_BYTE, 32'($urandom_range(0, 255)));
        end
      endcase
      begin : fill_phase
        int target;
        target = live_items + PHASE_ITEMS;
        while (live_items < target) gen_frame();
      end
      // long receiver stall while the queue is full, backs up the block
      if (p == 0) long_hold_req = 1'b1;
      wait_drained();
    end

    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // run limit, far beyond the slowest passing run
  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

endmodule

// File: sim.f
src/wsfb_pkg.sv
src/wsfb_compose.sv
src/websocket_masked_frame_builder_top.sv
src/wsfb_checker.sv
tb/sv/tb_websocket_masked_frame_builder_top.sv
